### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Default geometry, field widths, control character codes, the blank cell and operation codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int CHAR_W   = 8;
	localparam int COLOR_W  = 4;
	localparam int INDEX_W  = 11;
	localparam int CURSOR_W = 11;
	localparam int CELL_W   = 16;

	// blank cell: white on black space
	localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;

	// control characters
	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	// tab stops every eight columns
	localparam int TAB_STEP = 8;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUT   = 2'd0,
		OP_CLEAR = 2'd1,
		OP_READ  = 2'd2
	} op_t;

endpackage
`default_nettype wire

### rtl/tcw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/text_console_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Keeps ROWS x COLUMNS character cells in one RAM and a cursor in registers.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on the rising edge where start is high and busy is
//   low. operation selects put character, clear screen or read cell. Each
//   transaction gives exactly one result: done is high for one cycle with
//   cursor_location and cell_word; the receiver cannot stall.
//   put without scroll, ignored codes and out-of-range reads give done in the
//   cycle after they are taken. A read of a valid cell passes through the
//   registered RAM read and the S_READ state. A put that scrolls and a clear
//   run the RAM sweep that moves or blanks one cell a cycle over the single
//   write port, then S_DRAIN.
//   A new transaction may be started in the cycle that done is high.
//   After reset the block runs a clearing pass that blanks every cell,
//   holding busy high; no result is given for it. The cursor resets to the
//   home position.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [tcw_pkg::OP_W-1:0]       operation,
	input  wire logic [tcw_pkg::CHAR_W-1:0]     character,
	input  wire logic [tcw_pkg::COLOR_W-1:0]    bg_color,
	input  wire logic [tcw_pkg::COLOR_W-1:0]    fg_color,
	input  wire logic [tcw_pkg::INDEX_W-1:0]    cell_index,
	output logic                                done,
	output logic      [tcw_pkg::CURSOR_W-1:0]   cursor_location,
	output logic      [tcw_pkg::CELL_W-1:0]     cell_word
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int ADDR_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);
	localparam int COLW1      = COL_W + 1;
	localparam int ROWW1      = ROW_W + 1;
	localparam int WIDE_W     = ((ADDR_W > tcw_pkg::INDEX_W) ? ADDR_W : tcw_pkg::INDEX_W) + 1;
	localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
	localparam logic [ADDR_W-1:0] BLANK_FROM = ADDR_W'(CELL_COUNT - COLUMNS);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_READ  = 4'b0010,
		S_SWEEP = 4'b0100,
		S_DRAIN = 4'b1000
	} state_t;

	state_t              state_q;
	logic [COL_W-1:0]    col_q;
	logic [ROW_W-1:0]    row_q;
	logic [ADDR_W-1:0]   cnt_q;
	logic                scroll_q;
	logic                report_q;
	logic                done_q;
	logic [tcw_pkg::CELL_W-1:0] cell_word_q;

	logic                sweep_vld_s1;
	logic [ADDR_W-1:0]   sweep_addr_s1;
	logic                sweep_blank_s1;

	logic                accept;
	tcw_pkg::op_t        op;
	logic [WIDE_W-1:0]   lin;
	logic [WIDE_W-1:0]   idx_wide;
	logic                idx_ok;
	logic [WIDE_W-1:0]   src;
	logic                sweep_re;
	logic                read_issue;

	logic [COLW1-1:0]    col_ext;
	logic [COLW1-1:0]    col_n;
	logic [ROWW1-1:0]    row_n;
	logic                printable;
	logic                scroll_n;
	logic                put_we;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_rdata;

	assign accept = start && (state_q == S_IDLE);
	assign op     = tcw_pkg::op_t'(operation);

	// linear cursor position, shared by the write address and the report
	assign lin = WIDE_W'(row_q) * WIDE_W'(COLUMNS) + WIDE_W'(col_q);

	// range check of the read index
	assign idx_wide   = WIDE_W'(cell_index);
	assign idx_ok     = idx_wide < WIDE_W'(CELL_COUNT);
	assign read_issue = accept && (op == tcw_pkg::OP_READ) && idx_ok;

	// source cell for the scroll copy, one row below the destination
	assign src      = WIDE_W'(cnt_q) + WIDE_W'(COLUMNS);
	assign sweep_re = (state_q == S_SWEEP) && scroll_q && (src < WIDE_W'(CELL_COUNT));

	// next cursor for a put transaction
	assign col_ext = {1'b0, col_q};
	always_comb begin
		col_n     = col_ext;
		row_n     = {1'b0, row_q};
		printable = 1'b0;
		case (character)
			tcw_pkg::CHAR_BS: begin
				if (col_q != '0) begin
					col_n = col_ext - COLW1'(1);
				end
			end
			tcw_pkg::CHAR_TAB: begin
				col_n = (col_ext + COLW1'(tcw_pkg::TAB_STEP)) &
				        ~COLW1'(tcw_pkg::TAB_STEP - 1);
			end
			tcw_pkg::CHAR_CR: begin
				col_n = '0;
			end
			tcw_pkg::CHAR_LF: begin
				col_n = '0;
				row_n = row_n + ROWW1'(1);
			end
			default: begin
				if (character >= tcw_pkg::CHAR_SPACE) begin
					col_n     = col_ext + COLW1'(1);
					printable = 1'b1;
				end
			end
		endcase
		// wrap at the end of the line
		if (col_n >= COLW1'(COLUMNS)) begin
			col_n = '0;
			row_n = row_n + ROWW1'(1);
		end
	end
	assign scroll_n = row_n >= ROWW1'(ROWS);
	assign put_we   = accept && (op == tcw_pkg::OP_PUT) && printable;

	// RAM write port: sweep has the port whenever its pipeline stage is live
	assign ram_we    = sweep_vld_s1 || put_we;
	assign ram_waddr = sweep_vld_s1 ? sweep_addr_s1 : lin[ADDR_W-1:0];
	assign ram_wdata = sweep_vld_s1 ?
	                   (sweep_blank_s1 ? tcw_pkg::BLANK_CELL : ram_rdata) :
	                   {bg_color, fg_color, character};

	// RAM read port
	assign ram_re    = sweep_re || read_issue;
	assign ram_raddr = sweep_re ? src[ADDR_W-1:0] : idx_wide[ADDR_W-1:0];

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(CELL_COUNT)
	) u_cells (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control: sequencer, cursor and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			col_q        <= '0;
			row_q        <= '0;
			cnt_q        <= '0;
			scroll_q     <= 1'b0;
			report_q     <= 1'b0;
			done_q       <= 1'b0;
			sweep_vld_s1 <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			sweep_vld_s1 <= (state_q == S_SWEEP);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (op)
							tcw_pkg::OP_PUT: begin
								col_q <= col_n[COL_W-1:0];
								if (scroll_n) begin
									row_q    <= ROW_W'(ROWS - 1);
									scroll_q <= 1'b1;
									report_q <= 1'b1;
									cnt_q    <= '0;
									state_q  <= S_SWEEP;
								end else begin
									row_q  <= row_n[ROW_W-1:0];
									done_q <= 1'b1;
								end
							end
							tcw_pkg::OP_CLEAR: begin
								col_q    <= '0;
								row_q    <= '0;
								scroll_q <= 1'b0;
								report_q <= 1'b1;
								cnt_q    <= '0;
								state_q  <= S_SWEEP;
							end
							tcw_pkg::OP_READ: begin
								if (idx_ok) begin
									state_q <= S_READ;
								end else begin
									done_q <= 1'b1;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == LAST_CELL) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					done_q  <= report_q;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: sweep stage and result word
	always_ff @(posedge clk) begin
		sweep_addr_s1  <= cnt_q;
		sweep_blank_s1 <= !scroll_q || (cnt_q >= BLANK_FROM);
		cell_word_q    <= (state_q == S_READ) ? ram_rdata : '0;
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign cursor_location = lin[tcw_pkg::CURSOR_W-1:0];
	assign cell_word       = cell_word_q;

endmodule
`default_nettype wire

### rtl/tcw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the command handshake and the result strobe over time.
// ----------------------------------------------------------------------------
module tcw_checker (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         start,
	input wire logic                         busy,
	input wire logic [tcw_pkg::OP_W-1:0]     operation,
	input wire logic                         done,
	input wire logic [tcw_pkg::CELL_W-1:0]   cell_word
);

	logic accept;
	assign accept = start && !busy;

	// a taken transaction either reports at once or holds the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("transaction neither reported nor in progress");

	// a result only appears with the block free for the next transaction
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a result follows a taken transaction or the end of a busy period
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe with no transaction behind it");

	// a non-zero cell word comes only from a taken read that has passed through S_READ
	a_word_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (cell_word != '0)) |->
		$past(accept && (operation == tcw_pkg::OP_READ), 2))
		else $error("cell word reported for a transaction that is not a read");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.operation(operation),
	.done     (done),
	.cell_word(cell_word)
);
`default_nettype wire
